[rtl/mcc_pkg.sv]
package mcc_pkg;

	localparam int DEF_MAX_DENOMS = 8;
	localparam int DEF_MAX_AMOUNT = 1023;

	// Fixed widths of the item fields.
	localparam int VAL_W     = 10;
	localparam int IDX_OUT_W = 3;
	localparam int REQ_W     = 2;

	typedef enum logic [REQ_W-1:0] {
		REQ_CLEAR  = 2'd0,
		REQ_APPEND = 2'd1,
		REQ_SOLVE  = 2'd2
	} req_t;

	typedef enum logic [2:0] {
		SOLVE_IDLE,
		SOLVE_FILL,
		SOLVE_LAST,
		SOLVE_BT_RD,
		SOLVE_BT_UPD,
		SOLVE_EMIT
	} solve_state_t;

	typedef struct packed {
		logic [REQ_W-1:0] req_type;
		logic [VAL_W-1:0] coin_value;
		logic [VAL_W-1:0] amount;
	} in_item_t;

	typedef struct packed {
		logic [IDX_OUT_W-1:0] denom_index;
		logic [VAL_W-1:0]     denom_value;
		logic [VAL_W-1:0]     denom_uses;
		logic [VAL_W-1:0]     total_coins;
		logic                 reachable;
		logic                 last_result;
	} out_item_t;

	typedef struct packed {
		logic             start;
		logic [VAL_W-1:0] amount;
	} solve_cmd_t;

	typedef struct packed {
		logic busy;
		logic res_valid;
	} solve_sts_t;

endpackage

[rtl/mcc_solver.sv]
module mcc_solver #(
	parameter int MAX_DENOMS = mcc_pkg::DEF_MAX_DENOMS,
	parameter int MAX_AMOUNT = mcc_pkg::DEF_MAX_AMOUNT,
	parameter int CNT_W      = $clog2(MAX_DENOMS + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  mcc_pkg::solve_cmd_t      cmd,
	input  logic [CNT_W-1:0]         denom_count,
	input  logic [mcc_pkg::VAL_W-1:0] denoms [MAX_DENOMS],
	output mcc_pkg::solve_sts_t      sts,
	output mcc_pkg::out_item_t       res,
	input  logic                     res_ready
);
	import mcc_pkg::*;

	localparam int IDX_W     = (MAX_DENOMS > 1) ? $clog2(MAX_DENOMS) : 1;
	localparam int LIM       = (MAX_AMOUNT < 1023) ? MAX_AMOUNT : 1023;
	localparam int TBL_DEPTH = LIM + 1;
	localparam int ADDR_W    = $clog2(TBL_DEPTH);
	localparam int CMP_W     = (ADDR_W > VAL_W) ? ADDR_W : VAL_W;
	localparam int ENT_W     = 2 * VAL_W + IDX_W + 1;

	solve_state_t state_q, state_d;

	// Table entry: reachable flag, best count, chosen list position, chosen coin value.
	logic [ENT_W-1:0]  mem [TBL_DEPTH];
	logic [ENT_W-1:0]  mem_rd_q;
	logic [ADDR_W-1:0] rd_addr;

	logic [ADDR_W-1:0] amt_q, v_q, w_q;
	logic [CNT_W-1:0]  cnt_q, i_q;
	logic              empty_q, reach_q;
	logic [VAL_W-1:0]  total_q;
	logic [VAL_W-1:0]  uses_q [MAX_DENOMS];

	logic              rd_vld_s1, rd_skip_s1, rd_zero_s1;
	logic [IDX_W-1:0]  rd_idx_s1;
	logic [VAL_W-1:0]  rd_coin_s1;

	logic              best_vld_q;
	logic [VAL_W-1:0]  best_cnt_q, best_coin_q;
	logic [IDX_W-1:0]  best_idx_q;

	logic              e_vld;
	logic [VAL_W-1:0]  e_cnt, e_coin;
	logic [IDX_W-1:0]  e_idx;

	logic [VAL_W-1:0]  coin_i;
	logic [CMP_W-1:0]  coin_ext, v_ext, w_ext, bt_coin_ext, fill_diff, bt_diff;
	logic              coin_skip, coin_zero;

	logic              src_vld, take;
	logic [VAL_W-1:0]  src_cnt, cand;
	logic              m_vld;
	logic [VAL_W-1:0]  m_cnt, m_coin;
	logic [IDX_W-1:0]  m_idx;

	logic              amt_over, bt_ok, fill_last, res_last;
	logic [ADDR_W-1:0] w_next;

	assign e_vld  = mem_rd_q[ENT_W-1];
	assign e_cnt  = mem_rd_q[VAL_W+IDX_W +: VAL_W];
	assign e_idx  = mem_rd_q[VAL_W +: IDX_W];
	assign e_coin = mem_rd_q[VAL_W-1:0];

	assign coin_i    = denoms[i_q[IDX_W-1:0]];
	assign coin_ext  = CMP_W'(coin_i);
	assign v_ext     = CMP_W'(v_q);
	assign fill_diff = v_ext - coin_ext;
	assign coin_skip = (coin_i == '0) || (coin_ext > v_ext);
	assign coin_zero = (coin_ext == v_ext);

	assign w_ext       = CMP_W'(w_q);
	assign bt_coin_ext = CMP_W'(e_coin);
	assign bt_diff     = w_ext - bt_coin_ext;
	assign w_next      = bt_diff[ADDR_W-1:0];
	assign bt_ok       = (CNT_W'(e_idx) < cnt_q) && (e_coin != '0) && (bt_coin_ext <= w_ext);

	assign rd_addr = (state_q == SOLVE_FILL) ? fill_diff[ADDR_W-1:0] : w_q;

	// A sub-amount of exactly zero is formed by no coins; its count is taken as zero, not from the table.
	assign src_vld = rd_zero_s1 ? 1'b1 : e_vld;
	assign src_cnt = rd_zero_s1 ? '0 : e_cnt;
	assign cand    = src_cnt + VAL_W'(1);
	assign take    = rd_vld_s1 && !rd_skip_s1 && src_vld && (!best_vld_q || (best_cnt_q > cand));
	assign m_vld   = take ? 1'b1 : best_vld_q;
	assign m_cnt   = take ? cand : best_cnt_q;
	assign m_idx   = take ? rd_idx_s1 : best_idx_q;
	assign m_coin  = take ? rd_coin_s1 : best_coin_q;

	assign amt_over  = int'(cmd.amount) > MAX_AMOUNT;
	assign fill_last = (i_q == cnt_q - CNT_W'(1));
	assign res_last  = empty_q || (i_q + CNT_W'(1) == cnt_q);

	always_ff @(posedge clk) begin
		if (state_q == SOLVE_LAST) begin
			mem[v_q] <= {m_vld, m_cnt, m_idx, m_coin};
		end
		mem_rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SOLVE_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			SOLVE_IDLE: begin
				if (cmd.start) begin
					if (denom_count == '0 || amt_over || cmd.amount == '0) begin
						state_d = SOLVE_EMIT;
					end else begin
						state_d = SOLVE_FILL;
					end
				end
			end
			SOLVE_FILL: begin
				if (fill_last) begin
					state_d = SOLVE_LAST;
				end
			end
			SOLVE_LAST: begin
				if (v_q == amt_q) begin
					state_d = m_vld ? SOLVE_BT_RD : SOLVE_EMIT;
				end else begin
					state_d = SOLVE_FILL;
				end
			end
			SOLVE_BT_RD: begin
				state_d = SOLVE_BT_UPD;
			end
			SOLVE_BT_UPD: begin
				if (bt_ok && w_next != '0) begin
					state_d = SOLVE_BT_RD;
				end else begin
					state_d = SOLVE_EMIT;
				end
			end
			SOLVE_EMIT: begin
				if (res_ready && res_last) begin
					state_d = SOLVE_IDLE;
				end
			end
			default: begin
				state_d = SOLVE_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q        <= '0;
			rd_vld_s1  <= 1'b0;
			best_vld_q <= 1'b0;
			empty_q    <= 1'b0;
			reach_q    <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == SOLVE_FILL);
			case (state_q)
				SOLVE_IDLE: begin
					if (cmd.start) begin
						i_q        <= '0;
						best_vld_q <= 1'b0;
						empty_q    <= (denom_count == '0);
						reach_q    <= (cmd.amount == '0) && !amt_over;
					end
				end
				SOLVE_FILL: begin
					if (!fill_last) begin
						i_q <= i_q + CNT_W'(1);
					end
					best_vld_q <= m_vld;
				end
				SOLVE_LAST: begin
					i_q        <= '0;
					best_vld_q <= 1'b0;
					if (v_q == amt_q) begin
						reach_q <= m_vld;
					end
				end
				SOLVE_EMIT: begin
					if (res_ready && !res_last) begin
						i_q <= i_q + CNT_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1  <= i_q[IDX_W-1:0];
		rd_skip_s1 <= coin_skip;
		rd_zero_s1 <= coin_zero;
		rd_coin_s1 <= coin_i;
		case (state_q)
			SOLVE_IDLE: begin
				if (cmd.start) begin
					amt_q   <= ADDR_W'(cmd.amount);
					cnt_q   <= denom_count;
					v_q     <= ADDR_W'(1);
					total_q <= '0;
				end
			end
			SOLVE_FILL: begin
				best_cnt_q  <= m_cnt;
				best_idx_q  <= m_idx;
				best_coin_q <= m_coin;
			end
			SOLVE_LAST: begin
				v_q <= v_q + ADDR_W'(1);
				w_q <= amt_q;
				if (v_q == amt_q) begin
					total_q <= m_cnt;
				end
			end
			SOLVE_BT_UPD: begin
				if (bt_ok) begin
					w_q <= w_next;
				end
			end
			default: begin
			end
		endcase
	end

	// Each counter watches for its own list position during the backtrack walk.
	always_ff @(posedge clk) begin
		for (int j = 0; j < MAX_DENOMS; j++) begin
			if (state_q == SOLVE_IDLE && cmd.start) begin
				uses_q[j] <= '0;
			end else if (state_q == SOLVE_BT_UPD && bt_ok && e_idx == IDX_W'(j)) begin
				uses_q[j] <= uses_q[j] + VAL_W'(1);
			end
		end
	end

	always_comb begin
		res.denom_index = IDX_OUT_W'(i_q);
		res.denom_value = empty_q ? '0 : coin_i;
		res.denom_uses  = (reach_q && !empty_q) ? uses_q[i_q[IDX_W-1:0]] : '0;
		res.total_coins = reach_q ? total_q : '0;
		res.reachable   = reach_q;
		res.last_result = res_last;
	end

	assign sts.busy      = (state_q != SOLVE_IDLE);
	assign sts.res_valid = (state_q == SOLVE_EMIT);

endmodule

[rtl/min_coin_change_solver.sv]
// Minimum-coin change solver. Clear and append items give no result; the list
// holds up to MAX_DENOMS nonzero coin values. A solve item with a nonzero amount
// up to MAX_AMOUNT and a nonempty list fills a table of best counts for every
// value from 1 up to the amount, one list entry per cycle through a single read
// and write port on that table. A walk back from the amount, with a table read and
// an update per coin of the solution, follows when the amount is reachable. Then
// one result per loaded coin follows (a single result when the list is empty),
// one per cycle while the output side takes them. The block takes no new item
// until the last result of a solve sits in the output register.
module min_coin_change_solver #(
	parameter int MAX_DENOMS = mcc_pkg::DEF_MAX_DENOMS,
	parameter int MAX_AMOUNT = mcc_pkg::DEF_MAX_AMOUNT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  mcc_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output mcc_pkg::out_item_t out_item
);
	import mcc_pkg::*;

	localparam int IDX_W = (MAX_DENOMS > 1) ? $clog2(MAX_DENOMS) : 1;
	localparam int CNT_W = $clog2(MAX_DENOMS + 1);

	logic [VAL_W-1:0] denom_q [MAX_DENOMS];
	logic [CNT_W-1:0] count_q;
	logic             in_fire;
	solve_cmd_t       cmd;
	solve_sts_t       sts;
	out_item_t        res;
	logic             res_ready;
	logic             out_valid_q;
	out_item_t        out_q;

	assign in_ready  = !sts.busy;
	assign in_fire   = in_valid && in_ready;
	assign cmd.start = in_fire && (in_item.req_type == REQ_SOLVE);
	assign cmd.amount = in_item.amount;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (in_fire) begin
			case (in_item.req_type)
				REQ_CLEAR: begin
					count_q <= '0;
				end
				REQ_APPEND: begin
					if (in_item.coin_value != '0 && count_q < CNT_W'(MAX_DENOMS)) begin
						count_q <= count_q + CNT_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && in_item.req_type == REQ_APPEND && in_item.coin_value != '0
				&& count_q < CNT_W'(MAX_DENOMS)) begin
			denom_q[count_q[IDX_W-1:0]] <= in_item.coin_value;
		end
	end

	mcc_solver #(
		.MAX_DENOMS(MAX_DENOMS),
		.MAX_AMOUNT(MAX_AMOUNT),
		.CNT_W     (CNT_W)
	) u_solver (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.denom_count(count_q),
		.denoms     (denom_q),
		.sts        (sts),
		.res        (res),
		.res_ready  (res_ready)
	);

	// The solver hands over the next item only when the output register is empty or its item is being taken.
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= sts.res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && sts.res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule
